### sv/tchr_pkg.sv
// tile color histogram ranker: shared types, constants and opcodes
// no dependencies
package tchr_pkg;
  localparam int unsigned TileW   = 6;
  localparam int unsigned TileH   = 12;
  localparam int unsigned NPix    = TileW * TileH;
  localparam int unsigned PixW    = $clog2(NPix);
  localparam int unsigned CntW    = $clog2(NPix + 1);
  localparam int unsigned QDepth  = 2;
  localparam logic [PixW-1:0] LastPix = PixW'(NPix - 1);

  typedef enum logic [1:0] {
    OpWrite = 2'd0,
    OpFill  = 2'd1,
    OpQuery = 2'd2,
    OpNone  = 2'd3
  } op_e;

  // classified item from front to back
  typedef struct packed {
    op_e         op;
    logic        in_range;
    logic [PixW-1:0] addr;
    logic [7:0]  color;
    logic [6:0]  rank;
  } cmd_t;

  // per-pixel record from the count pass
  typedef struct packed {
    logic            first;
    logic [CntW-1:0] cnt;
  } rec_t;

  // result item
  typedef struct packed {
    logic       rank_valid;
    logic [7:0] ranked_color;
    logic       fully_transparent;
    logic [6:0] distinct_colors;
    logic [7:0] pixel_read;
    logic       status;
  } res_t;
endpackage

### sv/tchr_front.sv
// tile color histogram ranker: input classification and command queue
// depends on tchr_pkg
module tchr_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [23:0]   in_data_i,
  output logic          cmd_valid_o,
  input  logic          cmd_ready_i,
  output tchr_pkg::cmd_t cmd_o
);
  import tchr_pkg::*;

  cmd_t cmd_q [QDepth];
  logic [$clog2(QDepth)-1:0] wr_q, rd_q;
  logic [$clog2(QDepth):0] cnt_q;
  cmd_t cls;
  logic [2:0] col;
  logic [3:0] row;
  logic push, pop;

  // decode and range check
  always_comb begin
    col = in_data_i[4:2];
    row = in_data_i[8:5];
    cls.op = op_e'(in_data_i[1:0]);
    cls.in_range = (32'(col) < TileW) && (32'(row) < TileH);
    cls.addr = PixW'(32'(row) * TileW + 32'(col));
    cls.color = in_data_i[16:9];
    cls.rank = in_data_i[23:17];
  end

  assign in_ready_o  = (cnt_q != ($clog2(QDepth)+1)'(QDepth));
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o = cmd_q[rd_q];
  assign push = in_valid_i && in_ready_o;
  assign pop  = cmd_valid_o && cmd_ready_i;

  // queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= wr_q + 1'b1;
      if (pop) rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + ($clog2(QDepth)+1)'(push) - ($clog2(QDepth)+1)'(pop);
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) cmd_q[wr_q] <= cls;
  end
endmodule

### sv/tchr_back.sv
// tile color histogram ranker: pixel store and query sequencer
// depends on tchr_pkg
module tchr_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [8:0]     transp_i,
  input  logic           cmd_valid_i,
  output logic           cmd_ready_o,
  input  tchr_pkg::cmd_t cmd_i,
  output logic           res_valid_o,
  input  logic           res_ready_i,
  output tchr_pkg::res_t res_o
);
  import tchr_pkg::*;

  typedef enum logic [5:0] {
    StClear = 6'b000001,
    StIdle  = 6'b000010,
    StFill  = 6'b000100,
    StCount = 6'b001000,
    StRank  = 6'b010000,
    StOut   = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic [7:0] pix_q [NPix];
  rec_t rec_q [NPix];
  cmd_t cmd_q;
  res_t res_q, res_d;
  logic [7:0] fcol_q;
  logic [PixW-1:0] f_q;
  logic run_q, sv_q;
  logic [PixW-1:0] i_q, j_q, si_q, sj_q;
  logic [7:0] pi_q, pj_q;
  rec_t ri_q, rj_q;
  logic [CntW-1:0] acc_q, dist_q, opq_q, pos_q;
  logic first_q, all_q;
  logic accept, start, stop;
  logic pix_we;
  logic [PixW-1:0] pix_wa;
  logic [7:0] pix_wd;
  rec_t rec_wd;
  logic row_end, pair_last, eq, opq_pi, opq_pj, beats, cand, hit;
  logic first_n, all_n;
  logic [CntW-1:0] acc_n, dist_n, opq_n, pos_n;

  assign accept = (state_q == StIdle) && cmd_valid_i;
  assign cmd_ready_o = (state_q == StIdle);
  assign res_valid_o = (state_q == StOut);
  assign res_o = res_q;

  // pair stage: pixel i against pixel j, read data registered from the address and aligned with si/sj
  assign row_end = (sj_q == LastPix);
  assign pair_last = row_end && (si_q == LastPix);
  assign eq = (pj_q == pi_q);
  assign opq_pi = ({1'b0, pi_q} != transp_i);
  assign opq_pj = ({1'b0, pj_q} != transp_i);

  // count pass: occurrences of pixel i's color, first occurrence flag
  assign acc_n = acc_q + CntW'(eq);
  assign first_n = first_q && !(eq && (sj_q < si_q));
  assign dist_n = dist_q + CntW'(first_n);
  assign opq_n = opq_q + CntW'(first_n && opq_pi);
  assign all_n = all_q && !opq_pi;
  assign rec_wd = {first_n, acc_n};

  // rank pass: count distinct opaque colors that rank ahead of candidate i
  assign beats = (rj_q.cnt > ri_q.cnt) ||
                 ((rj_q.cnt == ri_q.cnt) && (pj_q < pi_q));
  assign cand = opq_pi && ri_q.first;
  assign pos_n = pos_q + CntW'(opq_pj && rj_q.first && (pj_q != pi_q) && beats);
  assign hit = sv_q && row_end && cand && (pos_n == CntW'(cmd_q.rank));

  // pair walk start and stop
  assign start = (accept && (cmd_i.op == OpQuery)) ||
                 ((state_q == StCount) && (state_d == StRank));
  assign stop = (state_d == StOut);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StClear: if (f_q == LastPix) state_d = StIdle;
      StIdle: begin
        if (cmd_valid_i) begin
          if (cmd_i.op == OpQuery) state_d = StCount;
          else if (cmd_i.op == OpFill) state_d = StFill;
          else state_d = StOut;
        end
      end
      StFill:  if (f_q == LastPix) state_d = StOut;
      StCount: begin
        if (sv_q && pair_last)
          state_d = (CntW'(cmd_q.rank) < opq_n) ? StRank : StOut;
      end
      StRank:  if (hit || (sv_q && pair_last)) state_d = StOut;
      StOut:   if (res_ready_i) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // result fields
  always_comb begin
    res_d = res_q;
    if (accept) begin
      res_d = '0;
      res_d.status = ((cmd_i.op == OpWrite) || (cmd_i.op == OpQuery)) && !cmd_i.in_range;
    end else if ((state_q == StCount) && sv_q && row_end) begin
      res_d.distinct_colors = 7'(dist_n);
      res_d.fully_transparent = all_n;
      if (cmd_q.in_range && (si_q == cmd_q.addr)) res_d.pixel_read = pi_q;
    end else if ((state_q == StRank) && hit) begin
      res_d.ranked_color = pi_q;
      res_d.rank_valid = 1'b1;
    end
  end

  // pixel store write port: clear and fill sweeps, single writes
  always_comb begin
    pix_we = 1'b0;
    pix_wa = f_q;
    pix_wd = fcol_q;
    if ((state_q == StClear) || (state_q == StFill)) begin
      pix_we = 1'b1;
    end else if (accept && (cmd_i.op == OpWrite) && cmd_i.in_range) begin
      pix_we = 1'b1;
      pix_wa = cmd_i.addr;
      pix_wd = cmd_i.color;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_we) pix_q[pix_wa] <= pix_wd;
  end

  // per-pixel records written at the end of each count row
  always_ff @(posedge clk_i) begin
    if ((state_q == StCount) && sv_q && row_end) rec_q[si_q] <= rec_wd;
  end

  // registered reads at the pair addresses
  always_ff @(posedge clk_i) begin
    pi_q <= pix_q[i_q];
    pj_q <= pix_q[j_q];
    ri_q <= rec_q[i_q];
    rj_q <= rec_q[j_q];
  end

  // state, command and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      cmd_q <= '0;
      res_q <= '0;
      fcol_q <= '0;
      f_q <= '0;
    end else begin
      state_q <= state_d;
      res_q <= res_d;
      if (accept) begin
        cmd_q <= cmd_i;
        if (cmd_i.op == OpFill) fcol_q <= cmd_i.color;
      end
      if ((state_q == StClear) || (state_q == StFill))
        f_q <= (f_q == LastPix) ? '0 : f_q + 1'b1;
    end
  end

  // pair address walk and stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      sv_q <= 1'b0;
      i_q <= '0;
      j_q <= '0;
      si_q <= '0;
      sj_q <= '0;
    end else begin
      if (start) begin
        run_q <= 1'b1;
        i_q <= '0;
        j_q <= '0;
      end else if (stop) begin
        run_q <= 1'b0;
      end else if (run_q) begin
        if (j_q == LastPix) begin
          j_q <= '0;
          if (i_q == LastPix) run_q <= 1'b0;
          else i_q <= i_q + 1'b1;
        end else begin
          j_q <= j_q + 1'b1;
        end
      end
      sv_q <= run_q && !stop;
      si_q <= i_q;
      sj_q <= j_q;
    end
  end

  // count and rank accumulators
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      dist_q <= '0;
      opq_q <= '0;
      pos_q <= '0;
      first_q <= 1'b1;
      all_q <= 1'b1;
    end else if (accept) begin
      acc_q <= '0;
      dist_q <= '0;
      opq_q <= '0;
      pos_q <= '0;
      first_q <= 1'b1;
      all_q <= 1'b1;
    end else if (sv_q && (state_q == StCount)) begin
      if (row_end) begin
        acc_q <= '0;
        first_q <= 1'b1;
        dist_q <= dist_n;
        opq_q <= opq_n;
        all_q <= all_n;
      end else begin
        acc_q <= acc_n;
        first_q <= first_n;
      end
    end else if (sv_q && (state_q == StRank)) begin
      pos_q <= row_end ? '0 : pos_n;
    end
  end
endmodule

### sv/tile_color_histogram_ranker_core.sv
// tile color histogram ranker top level: config register, front and back
// depends on tchr_pkg, tchr_front, tchr_back
// After reset the 72-pixel tile is cleared in a sweep before the first item is
// carried out. Items are handled one at a time: a write or an unused code gives
// its result the cycle after the back takes it, a fill sweeps the tile first. A
// query walks all 72x72 pixel pairs with one compare a cycle, first to count,
// then again, stopping early on a hit, to find the ranked color (skipped when
// the rank is not below the opaque color count). Each result holds until
// m_axis_tready; a two-entry queue in front accepts items while the back is
// busy, until the queue is full.
module tile_color_histogram_ranker_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [8:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // operation, col, row, color, rank
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata   // status, pixel_read, distinct_colors,
                                     // fully_transparent, ranked_color, rank_valid
);
  import tchr_pkg::*;

  logic [8:0] transp_q;
  logic cmd_valid, cmd_ready;
  cmd_t cmd;
  res_t res;

  // transparent index register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) transp_q <= 9'd256;
    else if (cfg_we_i) transp_q <= cfg_wdata_i;
  end

  tchr_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .in_data_i(s_axis_tdata),
    .cmd_valid_o(cmd_valid), .cmd_ready_i(cmd_ready), .cmd_o(cmd)
  );

  tchr_back u_back (
    .clk_i, .rst_ni, .transp_i(transp_q),
    .cmd_valid_i(cmd_valid), .cmd_ready_o(cmd_ready), .cmd_i(cmd),
    .res_valid_o(m_axis_tvalid), .res_ready_i(m_axis_tready), .res_o(res)
  );

  assign m_axis_tdata = {6'd0, res};

  // a result with bad rank never carries a color
  a_rank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !res.rank_valid |-> res.ranked_color == 8'd0) else $error("rank");
  // result holds while stalled
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(res)) else $error("hold");
endmodule

### sim/tb_tile_color_histogram_ranker_core.sv
// testbench for tile_color_histogram_ranker_core: directed table, then random items
// depends on tchr_pkg and the core; each result checked vs tile model or typed row
module tb_tile_color_histogram_ranker_core;
  import tchr_pkg::*;

  typedef struct {
    op_e        op;
    logic [2:0] col;
    logic [3:0] row;
    logic [7:0] color;
    logic [6:0] rank;
    bit         typed;
    res_t       res;
  } vec_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [8:0]  cfg_wdata_i = 9'd0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = 24'd0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;

  // tile model state
  logic [7:0] tile_pix [NPix];
  logic [8:0] transp_idx;

  res_t expected_results [$];
  int   err_cnt = 0;
  int   tx_idle = 0;
  int   rx_idle = 0;

  tile_color_histogram_ranker_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #800_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // update the tile for one item and work out its result
  function automatic res_t tile_step(vec_t v);
    res_t r;
    int   hist [256];
    int   distinct;
    int   opaque;
    int   pos;
    bit   all_tr;
    bit   in_rng;
    r = '0;
    in_rng = (v.col < TileW) && (v.row < TileH);
    case (v.op)
      OpWrite: begin
        if (in_rng) tile_pix[v.col + v.row * TileW] = v.color;
        else r.status = 1'b1;
      end
      OpFill: begin
        for (int i = 0; i < NPix; i++) tile_pix[i] = v.color;
      end
      OpQuery: begin
        distinct = 0;
        opaque = 0;
        all_tr = 1'b1;
        for (int c = 0; c < 256; c++) hist[c] = 0;
        for (int i = 0; i < NPix; i++) begin
          hist[tile_pix[i]]++;
          if ({1'b0, tile_pix[i]} != transp_idx) all_tr = 1'b0;
        end
        for (int c = 0; c < 256; c++) begin
          if (hist[c] > 0) begin
            distinct++;
            if (c != transp_idx) opaque++;
          end
        end
        r.status = !in_rng;
        r.pixel_read = in_rng ? tile_pix[v.col + v.row * TileW] : 8'd0;
        r.distinct_colors = distinct[6:0];
        r.fully_transparent = all_tr;
        // rank = number of opaque colors that beat this one
        if (v.rank < opaque) begin
          for (int c = 0; c < 256; c++) begin
            if (hist[c] == 0 || c == transp_idx) continue;
            pos = 0;
            for (int d = 0; d < 256; d++) begin
              if (d == c || hist[d] == 0 || d == transp_idx) continue;
              if (hist[d] > hist[c] || (hist[d] == hist[c] && d < c)) pos++;
            end
            if (pos == v.rank) begin
              r.ranked_color = c[7:0];
              r.rank_valid = 1'b1;
              break;
            end
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // send one item, record its expectation at acceptance
  task automatic send_item(vec_t v);
    res_t r;
    while ($urandom_range(99) < tx_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {v.rank, v.color, v.row, v.col, v.op};
    do @(posedge clk_i); while (!s_axis_tready);
    r = tile_step(v);
    expected_results.insert(expected_results.size(), v.typed ? v.res : r);
  endtask

  task automatic drain;
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  // block must be idle here
  task automatic write_transparent(logic [8:0] val);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    transp_idx = val;
  endtask

  // random item, mostly in range with colors from a small palette
  function automatic vec_t rand_item();
    vec_t v;
    int   p;
    logic [7:0] palette [6] = '{8'd0, 8'd1, 8'd7, 8'd128, 8'd200, 8'd255};
    v.typed = 1'b0;
    v.res = '0;
    p = $urandom_range(99);
    if (p < 68) v.op = OpWrite;
    else if (p < 76) v.op = OpFill;
    else if (p < 96) v.op = OpQuery;
    else v.op = OpNone;
    if ($urandom_range(9) == 0) begin
      v.col = 3'($urandom_range(7));
      v.row = 4'($urandom_range(15));
    end else begin
      v.col = 3'($urandom_range(TileW - 1));
      v.row = 4'($urandom_range(TileH - 1));
    end
    v.color = ($urandom_range(3) == 0) ? 8'($urandom_range(255))
                                       : palette[$urandom_range(5)];
    v.rank = ($urandom_range(4) == 0) ? 7'($urandom_range(127))
                                      : 7'($urandom_range(5));
    return v;
  endfunction

  // result checker and receiver stalls
  always @(posedge clk_i or negedge rst_ni) begin
    res_t got;
    res_t exp_r;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = res_t'(m_axis_tdata[25:0]);
        if (expected_results.size() == 0) begin
          $error("unexpected result item %h", m_axis_tdata);
          err_cnt++;
        end else begin
          exp_r = expected_results.pop_front();
          if (got.status !== exp_r.status) begin
            $error("status exp %0d got %0d", exp_r.status, got.status);
            err_cnt++;
          end
          if (got.pixel_read !== exp_r.pixel_read) begin
            $error("pixel_read exp %0d got %0d", exp_r.pixel_read, got.pixel_read);
            err_cnt++;
          end
          if (got.distinct_colors !== exp_r.distinct_colors) begin
            $error("distinct_colors exp %0d got %0d", exp_r.distinct_colors,
                   got.distinct_colors);
            err_cnt++;
          end
          if (got.fully_transparent !== exp_r.fully_transparent) begin
            $error("fully_transparent exp %0d got %0d", exp_r.fully_transparent,
                   got.fully_transparent);
            err_cnt++;
          end
          if (got.ranked_color !== exp_r.ranked_color) begin
            $error("ranked_color exp %0d got %0d", exp_r.ranked_color,
                   got.ranked_color);
            err_cnt++;
          end
          if (got.rank_valid !== exp_r.rank_valid) begin
            $error("rank_valid exp %0d got %0d", exp_r.rank_valid, got.rank_valid);
            err_cnt++;
          end
        end
      end
      m_axis_tready <= ($urandom_range(99) >= rx_idle);
    end
  end

  // main sequence
  initial begin
    vec_t dir_tab [$];
    logic [8:0] trans_set [6];
    res_t zero_r;
    res_t oor_r;
    zero_r = '0;
    oor_r = '0;
    oor_r.status = 1'b1;
    for (int i = 0; i < NPix; i++) tile_pix[i] = 8'd0;
    transp_idx = 9'd256;

    // directed rows: op, col, row, color, rank, typed, result
    dir_tab = '{
      '{OpQuery, 3'd0, 4'd0, 8'd0,   7'd0,   1'b0, zero_r},
      '{OpQuery, 3'd0, 4'd0, 8'd0,   7'd1,   1'b0, zero_r},
      '{OpWrite, 3'd7, 4'd0, 8'd5,   7'd0,   1'b1, oor_r},
      '{OpWrite, 3'd0, 4'd15, 8'd5,  7'd0,   1'b1, oor_r},
      '{OpWrite, 3'd6, 4'd11, 8'd5,  7'd0,   1'b1, oor_r},
      '{OpWrite, 3'd0, 4'd0, 8'd255, 7'd127, 1'b1, zero_r},
      '{OpWrite, 3'd5, 4'd11, 8'd128, 7'd0,  1'b1, zero_r},
      '{OpWrite, 3'd1, 4'd0, 8'd128, 7'd0,   1'b1, zero_r},
      '{OpQuery, 3'd5, 4'd11, 8'd0,  7'd0,   1'b0, zero_r},
      '{OpQuery, 3'd0, 4'd0, 8'd255, 7'd1,   1'b0, zero_r},
      '{OpQuery, 3'd0, 4'd0, 8'd0,   7'd2,   1'b0, zero_r},
      '{OpQuery, 3'd0, 4'd0, 8'd0,   7'd3,   1'b0, zero_r},
      '{OpQuery, 3'd7, 4'd15, 8'd0,  7'd127, 1'b0, zero_r},
      '{OpQuery, 3'd6, 4'd0, 8'd0,   7'd0,   1'b0, zero_r},
      '{OpNone,  3'd7, 4'd15, 8'd255, 7'd127, 1'b1, zero_r},
      '{OpFill,  3'd7, 4'd15, 8'd170, 7'd0,  1'b1, zero_r},
      '{OpQuery, 3'd2, 4'd3, 8'd0,   7'd0,   1'b0, zero_r},
      '{OpQuery, 3'd2, 4'd3, 8'd0,   7'd1,   1'b0, zero_r},
      '{OpFill,  3'd0, 4'd0, 8'd0,   7'd0,   1'b1, zero_r},
      '{OpWrite, 3'd3, 4'd5, 8'd255, 7'd0,   1'b1, zero_r},
      '{OpQuery, 3'd3, 4'd5, 8'd0,   7'd0,   1'b0, zero_r}
    };

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    tx_idle = 11;
    rx_idle = 67;
    foreach (dir_tab[i]) send_item(dir_tab[i]);
    drain();

    // fully transparent tile with index 0 as transparent
    write_transparent(9'd0);
    send_item('{OpQuery, 3'd0, 4'd0, 8'd0, 7'd0, 1'b0, zero_r});
    send_item('{OpFill, 3'd0, 4'd0, 8'd0, 7'd0, 1'b1, zero_r});
    send_item('{OpQuery, 3'd0, 4'd0, 8'd0, 7'd0, 1'b0, zero_r});
    drain();

    trans_set = '{9'd255, 9'd0, 9'd511, 9'd128, 9'd256, 9'($urandom_range(255))};
    for (int ph = 0; ph < 6; ph++) begin
      tx_idle = (ph < 2) ? 11 : (ph < 4) ? 67 : 0;
      rx_idle = (ph < 2) ? 67 : (ph < 4) ? 11 : 0;
      write_transparent(trans_set[ph]);
      repeat (265) send_item(rand_item());
      drain();
    end

    repeat (20) @(posedge clk_i);
    if (err_cnt == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule

### files.f
sv/tchr_pkg.sv
sv/tchr_front.sv
sv/tchr_back.sv
sv/tile_color_histogram_ranker_core.sv
sim/tb_tile_color_histogram_ranker_core.sv
